// ===== hw/rtl/tgdc_pkg.sv =====
package tgdc_pkg;

	localparam int unsigned MAX_POINTS_DEF = 64;
	localparam int unsigned FRAC_BITS      = 16;
	localparam int unsigned WEIGHT_FRAC    = 8;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned DIST_W     = COORD_W + 1;
	localparam int unsigned SQ_W       = 2 * DIST_W;
	localparam int unsigned ROOT_ITER  = DIST_W;
	localparam int unsigned REM_W      = DIST_W + 3;
	localparam int unsigned SUM_W      = 40;
	localparam int unsigned WEIGHT_W   = 16;
	localparam int unsigned W_W        = SUM_W + WEIGHT_W - WEIGHT_FRAC;
	localparam int unsigned COST_W     = 63;
	localparam int unsigned ACC_W      = COST_W + FRAC_BITS + 1;
	localparam int unsigned EXP_W      = 3;
	localparam int unsigned ITER_W     = $clog2(W_W + 1);
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [EXP_W-1:0] EXP_MIN = EXP_W'(1);
	localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(4);

	localparam logic [COORD_W-1:0]  THR_RESET    = 32'd91750;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd1280;
	localparam logic [EXP_W-1:0]    EXP_RESET    = 3'd1;
	localparam logic [COST_W-1:0]   COST_MAX     = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} point_t;

	typedef struct packed {
		logic [COST_W-1:0] cost_increment;
		logic              applied;
		logic              too_many_points;
	} result_t;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_ABS    = 11'b000_0000_0010,
		S_MUL    = 11'b000_0000_0100,
		S_SQRT   = 11'b000_0000_1000,
		S_ACC    = 11'b000_0001_0000,
		S_ROBOT  = 11'b000_0010_0000,
		S_DECIDE = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_WEIGHT = 11'b001_0000_0000,
		S_POW    = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_SQ,
		OP_WEIGHT,
		OP_POW
	} op_t;

endpackage

// ===== hw/rtl/trajectory_goal_distance_cost_core.sv =====
// channel  direction  handshake                    payload
// point    in         point_valid / point_stall    tgdc_pkg::point_t
// result   out        result_valid / result_stall  tgdc_pkg::result_t
// cfg      in         cfg_write                    cfg_index, cfg_data
//
// a counted point passes the shift-add squarer and the restoring root, then is transferred and
// accumulated; a point past the limit only sets the overflow flag
// a last point adds the robot distance and, when the robot is near and a point was counted,
// the divider, the weight and each further power step, then the load of the result; the
// shared squarer/multiplier and the bit-serial divider set the pace
// asynchronous reset clears the accumulators and loads the register defaults
// points are taken while a result waits on result_stall; the sequencer holds only at its final step
module trajectory_goal_distance_cost_core #(
	parameter int unsigned MAX_POINTS = tgdc_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 point_valid,
	output logic                                 point_stall,
	input  tgdc_pkg::point_t                     point,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output tgdc_pkg::result_t                    result,
	input  logic                                 cfg_write,
	input  logic [tgdc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tgdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int unsigned MS_W    = tgdc_pkg::ACC_W + 1;
	localparam int unsigned SUMX_W  = tgdc_pkg::SUM_W + 1;
	localparam int unsigned DIST_W  = tgdc_pkg::DIST_W;
	localparam int unsigned W_W     = tgdc_pkg::W_W;
	localparam int unsigned ACC_W   = tgdc_pkg::ACC_W;
	localparam int unsigned COST_W  = tgdc_pkg::COST_W;
	localparam int unsigned REM_W   = tgdc_pkg::REM_W;
	localparam int unsigned SUM_W   = tgdc_pkg::SUM_W;
	localparam int unsigned ITER_W  = tgdc_pkg::ITER_W;
	localparam int unsigned EXP_W   = tgdc_pkg::EXP_W;

	// configuration
	logic                                enable_q;
	logic signed [tgdc_pkg::COORD_W-1:0] goal_x_q;
	logic signed [tgdc_pkg::COORD_W-1:0] goal_y_q;
	logic signed [tgdc_pkg::COORD_W-1:0] robot_x_q;
	logic signed [tgdc_pkg::COORD_W-1:0] robot_y_q;
	logic [tgdc_pkg::COORD_W-1:0]        thr_q;
	logic [tgdc_pkg::WEIGHT_W-1:0]       weight_q;
	logic [EXP_W-1:0]                    exp_q;

	// control
	tgdc_pkg::state_t state_q;
	tgdc_pkg::op_t    op_q;
	logic [ITER_W-1:0] cnt_q;
	logic              robot_q;
	logic              last_q;
	logic [1:0]        pow_left_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic              overflow_q;
	logic              result_valid_q;

	// datapath
	logic signed [DIST_W-1:0] dx_q;
	logic signed [DIST_W-1:0] dy_q;
	logic [COST_W-1:0]        a_q;
	logic [W_W-1:0]           sb_q;
	logic [DIST_W-1:0]        c_q;
	logic [DIST_W-1:0]        sd_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     sticky_q;
	logic [DIST_W-1:0]        root_q;
	logic [REM_W-1:0]         rem_q;
	logic [CNT_W-1:0]         div_rem_q;
	logic [W_W-1:0]           w_q;
	logic [COST_W-1:0]        cost_q;
	logic                     applied_q;
	tgdc_pkg::result_t        result_q;

	logic                     accept;
	logic                     out_free;
	logic                     last_iter;
	logic                     at_limit;
	logic [DIST_W-1:0]        mag_x;
	logic [DIST_W-1:0]        mag_y;
	logic [MS_W-1:0]          mul_sum;
	logic                     sticky_next;
	logic [REM_W-1:0]         sq_sh;
	logic [REM_W-1:0]         sq_trial;
	logic                     sq_ge;
	logic [CNT_W:0]           div_sh;
	logic [CNT_W:0]           div_diff;
	logic                     div_ge;
	logic [SUMX_W-1:0]        sum_add;
	logic [SUM_W-1:0]         sum_sat;
	logic                     near;
	logic [1:0]               pow_steps;

	assign accept    = point_valid && (state_q == tgdc_pkg::S_IDLE);
	assign out_free  = !result_valid_q || !result_stall;
	assign last_iter = (cnt_q == ITER_W'(1));
	assign at_limit  = (count_q >= CNT_W'(MAX_POINTS));

	assign mag_x = dx_q[DIST_W-1] ? (~dx_q + DIST_W'(1)) : dx_q;
	assign mag_y = dy_q[DIST_W-1] ? (~dy_q + DIST_W'(1)) : dy_q;

	// shift-add step, msb first, with a sticky flag once the product passes the cost range
	assign mul_sum = {1'b0, acc_q[ACC_W-2:0], 1'b0}
		+ MS_W'(a_q & {COST_W{sb_q[W_W-1]}})
		+ MS_W'(c_q & {DIST_W{sd_q[DIST_W-1]}});
	assign sticky_next = sticky_q || mul_sum[ACC_W] || mul_sum[ACC_W-1];

	// restoring root, one bit per cycle
	assign sq_sh    = {rem_q[REM_W-3:0], acc_q[tgdc_pkg::SQ_W-1 -: 2]};
	assign sq_trial = REM_W'({root_q, 2'b01});
	assign sq_ge    = (sq_sh >= sq_trial);

	// restoring divide of the sum by the point count
	assign div_sh   = {div_rem_q, sum_q[SUM_W-1]};
	assign div_diff = div_sh - {1'b0, count_q};
	assign div_ge   = (div_sh >= {1'b0, count_q});

	assign sum_add = {1'b0, sum_q} + SUMX_W'(root_q);
	assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

	assign near = enable_q && (root_q < {1'b0, thr_q});

	always_comb begin
		if (exp_q <= tgdc_pkg::EXP_MIN) begin
			pow_steps = 2'd0;
		end else if (exp_q >= tgdc_pkg::EXP_MAX) begin
			pow_steps = 2'(tgdc_pkg::EXP_MAX - tgdc_pkg::EXP_MIN);
		end else begin
			pow_steps = 2'(exp_q - tgdc_pkg::EXP_MIN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b1;
			goal_x_q       <= '0;
			goal_y_q       <= '0;
			robot_x_q      <= '0;
			robot_y_q      <= '0;
			thr_q          <= tgdc_pkg::THR_RESET;
			weight_q       <= tgdc_pkg::WEIGHT_RESET;
			exp_q          <= tgdc_pkg::EXP_RESET;
			state_q        <= tgdc_pkg::S_IDLE;
			op_q           <= tgdc_pkg::OP_SQ;
			cnt_q          <= '0;
			robot_q        <= 1'b0;
			last_q         <= 1'b0;
			pow_left_q     <= '0;
			sum_q          <= '0;
			count_q        <= '0;
			overflow_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					tgdc_pkg::CFG_ENABLE:    enable_q  <= cfg_data[0];
					tgdc_pkg::CFG_GOAL_X:    goal_x_q  <= cfg_data;
					tgdc_pkg::CFG_GOAL_Y:    goal_y_q  <= cfg_data;
					tgdc_pkg::CFG_ROBOT_X:   robot_x_q <= cfg_data;
					tgdc_pkg::CFG_ROBOT_Y:   robot_y_q <= cfg_data;
					tgdc_pkg::CFG_THRESHOLD: thr_q     <= cfg_data;
					tgdc_pkg::CFG_WEIGHT:    weight_q  <= cfg_data[tgdc_pkg::WEIGHT_W-1:0];
					tgdc_pkg::CFG_EXPONENT:  exp_q     <= cfg_data[EXP_W-1:0];
					default: ;
				endcase
			end

			if (result_valid_q && !result_stall && (state_q != tgdc_pkg::S_OUT)) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				tgdc_pkg::S_IDLE: begin
					if (accept) begin
						last_q  <= point.last_point;
						robot_q <= 1'b0;
						if (at_limit) begin
							overflow_q <= 1'b1;
							state_q    <= point.last_point ? tgdc_pkg::S_ROBOT
								: tgdc_pkg::S_IDLE;
						end else begin
							state_q <= tgdc_pkg::S_ABS;
						end
					end
				end
				tgdc_pkg::S_ABS: begin
					op_q    <= tgdc_pkg::OP_SQ;
					cnt_q   <= ITER_W'(DIST_W);
					state_q <= tgdc_pkg::S_MUL;
				end
				tgdc_pkg::S_MUL: begin
					if (last_iter) begin
						unique case (op_q) inside
							tgdc_pkg::OP_SQ: begin
								cnt_q   <= ITER_W'(tgdc_pkg::ROOT_ITER);
								state_q <= tgdc_pkg::S_SQRT;
							end
							tgdc_pkg::OP_WEIGHT, tgdc_pkg::OP_POW: begin
								state_q <= (pow_left_q == 2'd0) ? tgdc_pkg::S_OUT
									: tgdc_pkg::S_POW;
							end
							default: state_q <= tgdc_pkg::S_OUT;
						endcase
					end else begin
						cnt_q <= cnt_q - ITER_W'(1);
					end
				end
				tgdc_pkg::S_SQRT: begin
					cnt_q <= cnt_q - ITER_W'(1);
					if (last_iter) begin
						state_q <= robot_q ? tgdc_pkg::S_DECIDE : tgdc_pkg::S_ACC;
					end
				end
				tgdc_pkg::S_ACC: begin
					sum_q   <= sum_sat;
					count_q <= count_q + CNT_W'(1);
					state_q <= last_q ? tgdc_pkg::S_ROBOT : tgdc_pkg::S_IDLE;
				end
				tgdc_pkg::S_ROBOT: begin
					robot_q <= 1'b1;
					state_q <= tgdc_pkg::S_ABS;
				end
				tgdc_pkg::S_DECIDE: begin
					if (near && (count_q != '0)) begin
						cnt_q   <= ITER_W'(SUM_W);
						state_q <= tgdc_pkg::S_DIV;
					end else begin
						state_q <= tgdc_pkg::S_OUT;
					end
				end
				tgdc_pkg::S_DIV: begin
					sum_q <= {sum_q[SUM_W-2:0], div_ge};
					cnt_q <= cnt_q - ITER_W'(1);
					if (last_iter) begin
						state_q <= tgdc_pkg::S_WEIGHT;
					end
				end
				tgdc_pkg::S_WEIGHT: begin
					op_q       <= tgdc_pkg::OP_WEIGHT;
					cnt_q      <= ITER_W'(tgdc_pkg::WEIGHT_W);
					pow_left_q <= pow_steps;
					state_q    <= tgdc_pkg::S_MUL;
				end
				tgdc_pkg::S_POW: begin
					op_q       <= tgdc_pkg::OP_POW;
					cnt_q      <= ITER_W'(W_W);
					pow_left_q <= pow_left_q - 2'd1;
					state_q    <= tgdc_pkg::S_MUL;
				end
				tgdc_pkg::S_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						sum_q          <= '0;
						count_q        <= '0;
						overflow_q     <= 1'b0;
						robot_q        <= 1'b0;
						last_q         <= 1'b0;
						state_q        <= tgdc_pkg::S_IDLE;
					end
				end
				default: state_q <= tgdc_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tgdc_pkg::S_IDLE: begin
				if (accept) begin
					dx_q <= DIST_W'(point.point_x) - DIST_W'(goal_x_q);
					dy_q <= DIST_W'(point.point_y) - DIST_W'(goal_y_q);
				end
			end
			tgdc_pkg::S_ROBOT: begin
				dx_q <= DIST_W'(robot_x_q) - DIST_W'(goal_x_q);
				dy_q <= DIST_W'(robot_y_q) - DIST_W'(goal_y_q);
			end
			tgdc_pkg::S_ABS: begin
				a_q      <= COST_W'(mag_x);
				sb_q     <= {mag_x, {(W_W - DIST_W){1'b0}}};
				c_q      <= mag_y;
				sd_q     <= mag_y;
				acc_q    <= '0;
				sticky_q <= 1'b0;
			end
			tgdc_pkg::S_MUL: begin
				acc_q    <= mul_sum[ACC_W-1:0];
				sticky_q <= sticky_next;
				sb_q     <= {sb_q[W_W-2:0], 1'b0};
				sd_q     <= {sd_q[DIST_W-2:0], 1'b0};
				if (last_iter) begin
					case (op_q)
						tgdc_pkg::OP_SQ: begin
							root_q <= '0;
							rem_q  <= '0;
						end
						tgdc_pkg::OP_WEIGHT: begin
							w_q    <= mul_sum[tgdc_pkg::WEIGHT_FRAC +: W_W];
							cost_q <= COST_W'(mul_sum[tgdc_pkg::WEIGHT_FRAC +: W_W]);
						end
						tgdc_pkg::OP_POW: begin
							cost_q <= sticky_next ? tgdc_pkg::COST_MAX
								: mul_sum[tgdc_pkg::FRAC_BITS +: COST_W];
						end
						default: ;
					endcase
				end
			end
			tgdc_pkg::S_SQRT: begin
				acc_q  <= {acc_q[ACC_W-3:0], 2'b00};
				root_q <= {root_q[DIST_W-2:0], sq_ge};
				rem_q  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
			end
			tgdc_pkg::S_DECIDE: begin
				applied_q <= near;
				div_rem_q <= '0;
				if (!(near && (count_q != '0))) begin
					cost_q <= '0;
				end
			end
			tgdc_pkg::S_DIV: begin
				div_rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
			end
			tgdc_pkg::S_WEIGHT: begin
				a_q      <= COST_W'(sum_q);
				sb_q     <= {weight_q, {(W_W - tgdc_pkg::WEIGHT_W){1'b0}}};
				c_q      <= '0;
				sd_q     <= '0;
				acc_q    <= '0;
				sticky_q <= 1'b0;
			end
			tgdc_pkg::S_POW: begin
				a_q      <= cost_q;
				sb_q     <= w_q;
				c_q      <= '0;
				sd_q     <= '0;
				acc_q    <= '0;
				sticky_q <= 1'b0;
			end
			tgdc_pkg::S_OUT: begin
				if (out_free) begin
					result_q.cost_increment  <= cost_q;
					result_q.applied         <= applied_q;
					result_q.too_many_points <= overflow_q;
				end
			end
			default: ;
		endcase
	end

	assign point_stall  = (state_q != tgdc_pkg::S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic point_valid = 1'b0;
	logic point_stall;
	tgdc_pkg::point_t point = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	tgdc_pkg::result_t result;
	logic cfg_write = 1'b0;
	logic [tgdc_pkg::CFG_IDX_W-1:0] cfg_index = tgdc_pkg::CFG_ENABLE;
	logic [tgdc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the registers
	logic m_enable = 1'b1;
	logic [31:0] m_goal_x = '0;
	logic [31:0] m_goal_y = '0;
	logic [31:0] m_robot_x = '0;
	logic [31:0] m_robot_y = '0;
	logic [31:0] m_thr = tgdc_pkg::THR_RESET;
	logic [15:0] m_weight = tgdc_pkg::WEIGHT_RESET;
	logic [2:0] m_exp = tgdc_pkg::EXP_RESET;

	// predictor copy of the trajectory accumulators
	logic [39:0] trail_sum = '0;
	int trail_count = 0;
	logic trail_over = 1'b0;

	tgdc_pkg::point_t pending_pts[$];
	tgdc_pkg::result_t due_results[$];
	tgdc_pkg::result_t want;
	int errors = 0;
	bit calm = 1'b0;
	bit pt_taken = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	logic [31:0] g_x, g_y;

	trajectory_goal_distance_cost_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point(point),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [65:0] span_sq(input logic [31:0] ax, ay, bx, by);
		logic [32:0] dx, dy, mx, my;
		dx = {ax[31], ax} - {bx[31], bx};
		dy = {ay[31], ay} - {by[31], by};
		mx = dx[32] ? -dx : dx;
		my = dy[32] ? -dy : dy;
		return 66'(mx) * 66'(mx) + 66'(my) * 66'(my);
	endfunction

	function automatic logic [33:0] floor_root(input logic [65:0] v);
		logic [33:0] root;
		logic [39:0] rem, trial;
		root = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = {rem[37:0], v[2*i +: 2]};
			trial = {4'b0, root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[32:0], 1'b1};
			end else begin
				root = {root[32:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic logic [63:0] frac_mul_sat(input logic [63:0] a, b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		if (p[127:79] != '0)
			return {1'b0, tgdc_pkg::COST_MAX};
		return {1'b0, p[78:16]};
	endfunction

	task automatic absorb_point(input tgdc_pkg::point_t p);
		logic [33:0] d;
		logic [40:0] s;
		logic [39:0] mean;
		logic [63:0] w, cost;
		logic near;
		int e;
		tgdc_pkg::result_t r;
		if (trail_count >= tgdc_pkg::MAX_POINTS_DEF) begin
			trail_over = 1'b1;
		end else begin
			d = floor_root(span_sq(p.point_x, p.point_y, m_goal_x, m_goal_y));
			s = 41'(trail_sum) + 41'(d);
			trail_sum = s[40] ? '1 : s[39:0];
			trail_count++;
		end
		if (!p.last_point)
			return;
		near = m_enable &&
			(span_sq(m_robot_x, m_robot_y, m_goal_x, m_goal_y) < 66'(m_thr) * 66'(m_thr));
		cost = '0;
		if (near) begin
			mean = trail_sum / 40'(trail_count);
			w = (64'(mean) * 64'(m_weight)) >> tgdc_pkg::WEIGHT_FRAC;
			e = (m_exp < tgdc_pkg::EXP_MIN) ? int'(tgdc_pkg::EXP_MIN)
				: (m_exp > tgdc_pkg::EXP_MAX) ? int'(tgdc_pkg::EXP_MAX) : int'(m_exp);
			cost = w;
			for (int k = 1; k < e; k++)
				cost = frac_mul_sat(cost, w);
		end
		r.cost_increment = cost[62:0];
		r.applied = near;
		r.too_many_points = trail_over;
		due_results.push_back(r);
		trail_sum = '0;
		trail_count = 0;
		trail_over = 1'b0;
	endtask

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic int draw_stall();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 80)
			return 0;
		if (r < 97)
			return $urandom_range(1, 4);
		return $urandom_range(20, 100);
	endfunction

	always @(posedge clk) begin
		pt_taken <= point_valid && !point_stall;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					tgdc_pkg::CFG_ENABLE:    m_enable = cfg_data[0];
					tgdc_pkg::CFG_GOAL_X:    m_goal_x = cfg_data;
					tgdc_pkg::CFG_GOAL_Y:    m_goal_y = cfg_data;
					tgdc_pkg::CFG_ROBOT_X:   m_robot_x = cfg_data;
					tgdc_pkg::CFG_ROBOT_Y:   m_robot_y = cfg_data;
					tgdc_pkg::CFG_THRESHOLD: m_thr = cfg_data;
					tgdc_pkg::CFG_WEIGHT:    m_weight = cfg_data[15:0];
					tgdc_pkg::CFG_EXPONENT:  m_exp = cfg_data[2:0];
					default: ;
				endcase
			end
			// transaction accepted on the point channel
			if (point_valid && !point_stall)
				absorb_point(point);
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$error("unexpected result cost_increment %0d", result.cost_increment);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (result.cost_increment !== want.cost_increment) begin
						$error("cost_increment expected %0d got %0d",
							want.cost_increment, result.cost_increment);
						errors++;
					end
					if (result.applied !== want.applied) begin
						$error("applied expected %0d got %0d", want.applied, result.applied);
						errors++;
					end
					if (result.too_many_points !== want.too_many_points) begin
						$error("too_many_points expected %0d got %0d",
							want.too_many_points, result.too_many_points);
						errors++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!point_valid || pt_taken) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				point_valid <= 1'b0;
			end else if (pending_pts.size() != 0) begin
				point <= pending_pts.pop_front();
				point_valid <= 1'b1;
				gap_left = draw_gap();
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result_stall <= 1'b1;
		end else begin
			stall_left = draw_stall();
			result_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left = stall_left - 1;
		end
	end

	task automatic write_reg(input logic [tgdc_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push_point(input logic [31:0] x, y, input logic last);
		tgdc_pkg::point_t p;
		p.point_x = x;
		p.point_y = y;
		p.last_point = last;
		pending_pts.push_back(p);
	endtask

	task automatic drain();
		while (pending_pts.size() != 0 || point_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// idle long enough for a last point to clear the pipeline
	task automatic settle();
		drain();
		repeat (300) @(negedge clk);
	endtask

	function automatic logic [31:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic logic [31:0] pick_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 32'($signed($urandom()) >>> $urandom_range(8, 30));
		if (r < 8)
			return $urandom();
		return extreme_coord();
	endfunction

	function automatic logic [31:0] near_coord(input logic [31:0] base);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return base + 32'($signed($urandom()) >>> $urandom_range(6, 30));
		if (r < 9)
			return $urandom();
		return extreme_coord();
	endfunction

	task automatic pick_config();
		logic [31:0] thr;
		logic [15:0] wt;
		g_x = pick_coord();
		g_y = pick_coord();
		write_reg(tgdc_pkg::CFG_ENABLE, ($urandom_range(0, 6) != 0) ? 32'd1 : 32'd0);
		write_reg(tgdc_pkg::CFG_GOAL_X, g_x);
		write_reg(tgdc_pkg::CFG_GOAL_Y, g_y);
		if ($urandom_range(0, 9) < 7) begin
			write_reg(tgdc_pkg::CFG_ROBOT_X,
				g_x + 32'($signed($urandom()) >>> $urandom_range(12, 30)));
			write_reg(tgdc_pkg::CFG_ROBOT_Y,
				g_y + 32'($signed($urandom()) >>> $urandom_range(12, 30)));
		end else begin
			write_reg(tgdc_pkg::CFG_ROBOT_X, pick_coord());
			write_reg(tgdc_pkg::CFG_ROBOT_Y, pick_coord());
		end
		case ($urandom_range(0, 7))
			0: thr = '0;
			1: thr = '1;
			2: thr = tgdc_pkg::THR_RESET;
			default: thr = $urandom() >> $urandom_range(0, 20);
		endcase
		write_reg(tgdc_pkg::CFG_THRESHOLD, thr);
		case ($urandom_range(0, 7))
			0: wt = '0;
			1: wt = '1;
			default: wt = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
		endcase
		write_reg(tgdc_pkg::CFG_WEIGHT, 32'(wt));
		write_reg(tgdc_pkg::CFG_EXPONENT, 32'($urandom_range(0, 7)));
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			return $urandom_range(1, 10);
		if (r < 90)
			return $urandom_range(11, 63);
		return $urandom_range(64, 72);
	endfunction

	initial begin
		int n, len;
		bit split_done;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// register defaults: goal and robot at origin, cost applies
		push_point(32'h0000_0000, 32'h0000_0000, 1'b1);
		push_point(32'h0001_0000, 32'h0000_0000, 1'b1);
		push_point(32'h8000_0000, 32'h8000_0000, 1'b1);
		push_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		push_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
		push_point(32'hffff_ffff, 32'h0000_0001, 1'b0);
		push_point(32'h0003_0000, 32'h0004_0000, 1'b1);
		settle();

		// widest span, full weight, highest power saturates
		write_reg(tgdc_pkg::CFG_GOAL_X, 32'h7fff_ffff);
		write_reg(tgdc_pkg::CFG_GOAL_Y, 32'h7fff_ffff);
		write_reg(tgdc_pkg::CFG_ROBOT_X, 32'h7fff_ffff);
		write_reg(tgdc_pkg::CFG_ROBOT_Y, 32'h7fff_ffff);
		write_reg(tgdc_pkg::CFG_THRESHOLD, 32'hffff_ffff);
		write_reg(tgdc_pkg::CFG_WEIGHT, 32'h0000_ffff);
		write_reg(tgdc_pkg::CFG_EXPONENT, 32'd4);
		push_point(32'h8000_0000, 32'h8000_0000, 1'b1);
		settle();
		// exponent outside 1..4 is clamped
		write_reg(tgdc_pkg::CFG_EXPONENT, 32'd0);
		push_point(32'h8000_0000, 32'h7fff_0000, 1'b1);
		settle();
		write_reg(tgdc_pkg::CFG_EXPONENT, 32'd7);
		write_reg(tgdc_pkg::CFG_WEIGHT, 32'd1);
		push_point(32'h7ffe_ffff, 32'h7fff_ffff, 1'b1);
		settle();
		write_reg(tgdc_pkg::CFG_EXPONENT, 32'd5);
		push_point(32'h7fe0_0000, 32'h7ff0_0000, 1'b1);
		settle();
		// disabled: zero cost
		write_reg(tgdc_pkg::CFG_ENABLE, 32'd0);
		push_point(32'h0000_0000, 32'h0000_0000, 1'b1);
		settle();
		// robot exactly on the threshold is not near, one lsb inside is
		write_reg(tgdc_pkg::CFG_ENABLE, 32'd1);
		write_reg(tgdc_pkg::CFG_WEIGHT, 32'(tgdc_pkg::WEIGHT_RESET));
		write_reg(tgdc_pkg::CFG_EXPONENT, 32'd2);
		write_reg(tgdc_pkg::CFG_GOAL_X, 32'h0000_0000);
		write_reg(tgdc_pkg::CFG_GOAL_Y, 32'h0000_0000);
		write_reg(tgdc_pkg::CFG_ROBOT_X, 32'hffff_0000);
		write_reg(tgdc_pkg::CFG_ROBOT_Y, 32'h0000_0000);
		write_reg(tgdc_pkg::CFG_THRESHOLD, 32'h0001_0000);
		push_point(32'h0001_0000, 32'h0001_0000, 1'b1);
		settle();
		write_reg(tgdc_pkg::CFG_ROBOT_X, 32'hffff_0001);
		push_point(32'h0001_0000, 32'h0001_0000, 1'b1);
		settle();
		write_reg(tgdc_pkg::CFG_THRESHOLD, 32'h0000_0000);
		push_point(32'h0001_0000, 32'h0001_0000, 1'b1);

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			calm = ($urandom_range(0, 3) == 0);
			pick_config();
			n = 0;
			split_done = 1'b0;
			while (n < 122) begin
				len = (ph == 2 && !split_done) ? 8 : pick_len();
				for (int k = 0; k < len; k++) begin
					// hold the sender mid-trajectory until the block has gone quiet
					if (ph == 2 && !split_done && k == len / 2)
						drain();
					push_point(near_coord(g_x), near_coord(g_y), k == len - 1);
				end
				split_done = 1'b1;
				n += len;
			end
		end

		settle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
